FILE: src/caspol_pkg.sv
//------------------------------------------------------------------------------
// caspol_pkg: shared types and constants for the complex add/sub to polar block
// Holds the CORDIC vector word, kind codes, format constants and the
// arctangent table used by the pipelined vectoring stages.
//------------------------------------------------------------------------------
`default_nettype none

package caspol_pkg;

    // Default configuration of the top level
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF  = 16;

    // Kind codes
    localparam logic [1:0] KIND_A_ONLY = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_SUB    = 2'd2;

    // Vector words are aligned so the combined A/B sum MSB sits at bit 37
    localparam int GUARD_TOP = 37;
    localparam int VEC_W     = 40;
    localparam int Z_W       = 26;

    // Output field widths
    localparam int MAG_W = 18;
    localparam int ANG_W = 16;

    // Angle accumulator counts 1/65536 degree
    localparam logic signed [Z_W-1:0] DEG180     = 26'sd11796480;
    localparam logic [23:0]           INV_GAIN   = 24'd10188014;
    localparam logic [MAG_W-1:0]      MAG_MAX    = 18'd262143;
    localparam int                    ANGLE_FULL = 46080;
    localparam int                    ANGLE_HALF = 23040;

    // One CORDIC vector word travelling down the pipeline
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [Z_W-1:0]   z;
        logic                    zero;
    } caspol_vec_t;

    // atan(2^-idx) in degrees times 65536, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_deg16(input int idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:       val = 26'sd2949120;
            1:       val = 26'sd1740967;
            2:       val = 26'sd919879;
            3:       val = 26'sd466945;
            4:       val = 26'sd234379;
            5:       val = 26'sd117304;
            6:       val = 26'sd58666;
            7:       val = 26'sd29335;
            8:       val = 26'sd14668;
            9:       val = 26'sd7334;
            10:      val = 26'sd3667;
            11:      val = 26'sd1833;
            12:      val = 26'sd917;
            13:      val = 26'sd458;
            14:      val = 26'sd229;
            15:      val = 26'sd115;
            16:      val = 26'sd57;
            17:      val = 26'sd29;
            18:      val = 26'sd14;
            19:      val = 26'sd7;
            20:      val = 26'sd4;
            21:      val = 26'sd2;
            22:      val = 26'sd1;
            default: val = 26'sd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: src/caspol_prep.sv
//------------------------------------------------------------------------------
// caspol_prep: operand combine and half-plane pre-rotation
// Stage one forms A, A+B or A-B; stage two flags the zero vector, folds the
// left half-plane by 180 degrees and aligns the parts to the vector word.
//------------------------------------------------------------------------------
`default_nettype none

module caspol_prep
    import caspol_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            in_valid,
    input  wire logic        [1:0]               kind,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_real,
    input  wire logic signed [OPERAND_WIDTH-1:0] a_imag,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_real,
    input  wire logic signed [OPERAND_WIDTH-1:0] b_imag,
    output logic                                 out_valid,
    output caspol_vec_t                          out_vec
);

    localparam int SUM_W = OPERAND_WIDTH + 1;
    localparam int NEG_W = OPERAND_WIDTH + 2;
    localparam int GUARD = GUARD_TOP - OPERAND_WIDTH;

    logic signed [SUM_W-1:0] x1_next;
    logic signed [SUM_W-1:0] y1_next;
    logic signed [SUM_W-1:0] x1_reg;
    logic signed [SUM_W-1:0] y1_reg;
    logic                    v1_reg;

    caspol_vec_t vec_next;
    caspol_vec_t vec_reg;
    logic        v2_reg;

    // Combine operands by kind
    always_comb
    begin
        unique case (kind)
            KIND_ADD:
            begin
                x1_next = SUM_W'(a_real) + SUM_W'(b_real);
                y1_next = SUM_W'(a_imag) + SUM_W'(b_imag);
            end
            KIND_SUB:
            begin
                x1_next = SUM_W'(a_real) - SUM_W'(b_real);
                y1_next = SUM_W'(a_imag) - SUM_W'(b_imag);
            end
            default:
            begin
                x1_next = SUM_W'(a_real);
                y1_next = SUM_W'(a_imag);
            end
        endcase
    end

    // Fold left half-plane and align to the vector word
    always_comb
    begin
        logic signed [NEG_W-1:0] xe;
        logic signed [NEG_W-1:0] ye;
        xe = NEG_W'(x1_reg);
        ye = NEG_W'(y1_reg);
        vec_next.zero = (x1_reg == '0) && (y1_reg == '0);
        vec_next.z    = '0;
        if (x1_reg[SUM_W-1])
        begin
            vec_next.z = y1_reg[SUM_W-1] ? -DEG180 : DEG180;
            xe = -xe;
            ye = -ye;
        end
        vec_next.x = VEC_W'(xe) <<< GUARD;
        vec_next.y = VEC_W'(ye) <<< GUARD;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
            vec_reg <= vec_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

FILE: src/caspol_cordic_stage.sv
//------------------------------------------------------------------------------
// caspol_cordic_stage: one registered CORDIC vectoring iteration
// Rotates toward the x axis by atan(2^-SHIFT) and accumulates the angle.
//------------------------------------------------------------------------------
`default_nettype none

module caspol_cordic_stage
    import caspol_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire caspol_vec_t in_vec,
    output logic             out_valid,
    output caspol_vec_t      out_vec
);

    localparam logic signed [Z_W-1:0] ATAN_STEP = atan_deg16(SHIFT);

    caspol_vec_t vec_next;
    caspol_vec_t vec_reg;
    logic        valid_reg;

    // Clockwise when y is non-negative, counterclockwise otherwise
    always_comb
    begin
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        dx = in_vec.y >>> SHIFT;
        dy = in_vec.x >>> SHIFT;
        vec_next.zero = in_vec.zero;
        if (!in_vec.y[VEC_W-1])
        begin
            vec_next.x = in_vec.x + dx;
            vec_next.y = in_vec.y - dy;
            vec_next.z = in_vec.z + ATAN_STEP;
        end
        else
        begin
            vec_next.x = in_vec.x - dx;
            vec_next.y = in_vec.y + dy;
            vec_next.z = in_vec.z - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

FILE: src/caspol_post.sv
//------------------------------------------------------------------------------
// caspol_post: gain removal, rounding and angle wrap
// Stage one takes two partial products of x times the inverse gain and rounds
// the angle; stage two sums, rounds and saturates the magnitude, wraps the
// angle into (-180, 180] and holds the output word.
//------------------------------------------------------------------------------
`default_nettype none

module caspol_post
    import caspol_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire caspol_vec_t        in_vec,
    output logic                    out_valid,
    output logic        [MAG_W-1:0] magnitude,
    output logic signed [ANG_W-1:0] angle,
    output logic                    zero_vector
);

    localparam int GUARD     = GUARD_TOP - OPERAND_WIDTH;
    localparam int MAG_SHIFT = 24 + GUARD - 8;
    localparam int LO_W      = 20;
    localparam int HI_W      = VEC_W - 1 - LO_W;
    localparam int PLO_W     = LO_W + 24;
    localparam int PHI_W     = HI_W + 24;
    localparam int PROD_W    = 64;
    localparam int ANGR_W    = Z_W - 8;

    localparam logic signed [ANGR_W-1:0] ANG_HI   = ANGR_W'(ANGLE_HALF);
    localparam logic signed [ANGR_W-1:0] ANG_LO   = -ANGR_W'(ANGLE_HALF);
    localparam logic signed [ANGR_W-1:0] ANG_WRAP = ANGR_W'(ANGLE_FULL);

    logic        [PLO_W-1:0]  plo_reg;
    logic        [PHI_W-1:0]  phi_reg;
    logic signed [ANGR_W-1:0] angr_reg;
    logic                     zero_reg;
    logic                     v1_reg;

    logic signed [ANGR_W-1:0] angr_next;

    logic        [MAG_W-1:0]  mag_next;
    logic signed [ANG_W-1:0]  ang_next;
    logic        [MAG_W-1:0]  mag_reg;
    logic signed [ANG_W-1:0]  ang_reg;
    logic                     zv_reg;
    logic                     v2_reg;

    // Round angle half up from 1/65536 to 1/128 degree
    always_comb
    begin
        logic signed [Z_W:0] zr;
        zr        = (Z_W + 1)'(in_vec.z) + (Z_W + 1)'(256);
        angr_next = ANGR_W'(zr >>> 9);
    end

    // Sum partial products, round, saturate and wrap
    always_comb
    begin
        logic [PROD_W-1:0]        prod;
        logic [PROD_W-1:0]        mag_wide;
        logic signed [ANGR_W-1:0] aw;
        prod = (PROD_W'(phi_reg) << LO_W) + PROD_W'(plo_reg)
             + (PROD_W'(1) << (MAG_SHIFT - 1));
        mag_wide = prod >> MAG_SHIFT;
        if (mag_wide > PROD_W'(MAG_MAX))
        begin
            mag_next = MAG_MAX;
        end
        else
        begin
            mag_next = mag_wide[MAG_W-1:0];
        end
        aw = angr_reg;
        if (angr_reg > ANG_HI)
        begin
            aw = angr_reg - ANG_WRAP;
        end
        else if (angr_reg <= ANG_LO)
        begin
            aw = angr_reg + ANG_WRAP;
        end
        ang_next = aw[ANG_W-1:0];
        if (zero_reg)
        begin
            mag_next = '0;
            ang_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Partial products and output word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg  <= PLO_W'(in_vec.x[LO_W-1:0]) * PLO_W'(INV_GAIN);
            phi_reg  <= PHI_W'(in_vec.x[VEC_W-2:LO_W]) * PHI_W'(INV_GAIN);
            angr_reg <= angr_next;
            zero_reg <= in_vec.zero;
            mag_reg  <= mag_next;
            ang_reg  <= ang_next;
            zv_reg   <= zero_reg;
        end
    end

    assign out_valid   = v2_reg;
    assign magnitude   = mag_reg;
    assign angle       = ang_reg;
    assign zero_vector = zv_reg;

endmodule

`default_nettype wire

FILE: src/complex_add_sub_to_polar_top.sv
//------------------------------------------------------------------------------
// complex_add_sub_to_polar_top: complex add/subtract and polar conversion
// Input word on s_*: s_tdata holds a_real, a_imag, b_real, b_imag (Q8.8,
// OPERAND_WIDTH bits each, lowest first), s_tuser holds the kind (0 = A,
// 1 = A+B, 2 = A-B, 3 acts as 0). Output word on m_*: m_tdata holds the
// magnitude (18 bits, 16 fraction bits) then the signed angle in 1/128
// degree; m_tuser flags a zero vector (angle and magnitude then 0).
// The pipeline has two prep stages, one stage per CORDIC iteration and two
// for gain removal and rounding. Throughput is one word per cycle while the
// output is not stalled; every stage is a register and valid bits travel
// with the data.
// All stages share one advance enable: the pipe moves when the output
// register is empty or being taken. While the receiver stalls with a word
// held, s_tready drops and every stage holds; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready right after reset.
//------------------------------------------------------------------------------
`default_nettype none

module complex_add_sub_to_polar_top
    import caspol_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // a_real, a_imag, b_real, b_imag, zero pad to bytes
    input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_tdata,
    // kind
    input  wire logic [1:0]                             s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // magnitude, angle, zero pad to bytes
    output logic [39:0]                                 m_tdata,
    // zero_vector
    output logic [0:0]                                  m_tuser
);

    localparam int OW = OPERAND_WIDTH;

    logic en;

    logic        stage_valid [CORDIC_STEPS+1];
    caspol_vec_t stage_vec   [CORDIC_STEPS+1];

    logic                    post_valid;
    logic        [MAG_W-1:0] magnitude;
    logic signed [ANG_W-1:0] angle;
    logic                    zero_vector;

    // Advance the whole pipe when the output word is free or taken
    assign en       = !post_valid || m_tready;
    assign s_tready = en;

    caspol_prep #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .kind      (s_tuser),
        .a_real    (s_tdata[OW-1:0]),
        .a_imag    (s_tdata[2*OW-1:OW]),
        .b_real    (s_tdata[3*OW-1:2*OW]),
        .b_imag    (s_tdata[4*OW-1:3*OW]),
        .out_valid (stage_valid[0]),
        .out_vec   (stage_vec[0])
    );

    // One registered stage per CORDIC iteration
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        caspol_cordic_stage #(
            .SHIFT (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[i]),
            .in_vec    (stage_vec[i]),
            .out_valid (stage_valid[i+1]),
            .out_vec   (stage_vec[i+1])
        );
    end

    caspol_post #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (stage_valid[CORDIC_STEPS]),
        .in_vec      (stage_vec[CORDIC_STEPS]),
        .out_valid   (post_valid),
        .magnitude   (magnitude),
        .angle       (angle),
        .zero_vector (zero_vector)
    );

    // Pack the output word
    assign m_tvalid = post_valid;
    assign m_tdata  = {6'b0, angle, magnitude};
    assign m_tuser  = zero_vector;

endmodule

`default_nettype wire
